// File: hdl/urbe_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the UART ring-buffer engine.
// Used by urbe_ctrl, urbe_datapath and uart_ring_buffer_engine; depends on nothing.

package urbe_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_LINE_RX  = 2'd0;
    localparam logic [1:0] OP_TX_EMPTY = 2'd1;
    localparam logic [1:0] OP_HOST_RD  = 2'd2;
    localparam logic [1:0] OP_HOST_WR  = 2'd3;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;

    // Default queue sizes in slots (one slot always kept empty)
    localparam int RX_DEPTH_DEF = 128;
    localparam int TX_DEPTH_DEF = 128;

    // Input beat: data [7:0], line_idle [8], zero fill to 16 bits
    localparam int IN_TDATA_W  = 16;
    localparam int IN_IDLE_BIT = 8;

    // Output beat layout, zero fill to 24 bits
    localparam int OUT_TDATA_W    = 24;
    localparam int OUT_RBYTE_LSB  = 0;
    localparam int OUT_RVALID_BIT = 8;
    localparam int OUT_SBYTE_LSB  = 9;
    localparam int OUT_SVALID_BIT = 17;
    localparam int OUT_IRQ_BIT    = 18;
    localparam int OUT_DROP_BIT   = 19;
    localparam int OUT_USED_W     = 20;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the incoming beat
        logic exec;     // update queues, pointers and interrupt enable
        logic load;     // build the result beat into the output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_stall;  // output register holds a beat that is not taken this cycle
    } sts_t;

endpackage

// File: hdl/urbe_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the UART ring-buffer engine: accept, execute, load result.
// Depends on urbe_pkg for the command and status structs.

module urbe_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  urbe_pkg::sts_t   sts,
    output urbe_pkg::cmd_t   cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FORM = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = ST_FORM;
            end
            ST_FORM:
            begin
                // wait for room in the output register
                if (!sts.out_stall)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/urbe_datapath.sv
`timescale 1ns / 1ps
// Datapath of the UART ring-buffer engine: both byte queues, their pointers,
// the interrupt enable and the output register. Depends on urbe_pkg.

module urbe_datapath
#(
    parameter int RX_DEPTH = urbe_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbe_pkg::TX_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  urbe_pkg::cmd_t                     cmd,
    output urbe_pkg::sts_t                     sts,
    input  logic [urbe_pkg::OP_W-1:0]          in_op,
    input  logic [urbe_pkg::BYTE_W-1:0]        in_data,
    input  logic                               in_idle,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [urbe_pkg::OUT_TDATA_W-1:0]   out_data
);

    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

    // Queue storage
    logic [urbe_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
    logic [urbe_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];
    logic [urbe_pkg::BYTE_W-1:0] rx_rd_reg;
    logic [urbe_pkg::BYTE_W-1:0] tx_rd_reg;

    // Captured beat
    logic [urbe_pkg::OP_W-1:0]   op_reg;
    logic [urbe_pkg::BYTE_W-1:0] data_reg;
    logic                        idle_reg;

    // Pointers and interrupt enable
    logic [RX_AW-1:0] rx_head_reg, rx_tail_reg;
    logic [TX_AW-1:0] tx_head_reg, tx_tail_reg;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;
    logic             irq_reg;
    logic             irq_next;

    // Step outcome
    logic rx_wr, rx_rd, tx_wr, tx_rd, direct, drop;
    logic rvalid_reg, svalid_reg, direct_reg, drop_reg;

    // Output register
    logic                            out_valid_reg;
    logic [urbe_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic [urbe_pkg::BYTE_W-1:0]     rbyte;
    logic [urbe_pkg::BYTE_W-1:0]     sbyte;

    // Wrapping increments
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;

    // Operation decode
    always_comb
    begin
        rx_wr    = 1'b0;
        rx_rd    = 1'b0;
        tx_wr    = 1'b0;
        tx_rd    = 1'b0;
        direct   = 1'b0;
        drop     = 1'b0;
        irq_next = irq_reg;
        unique case (op_reg)
            urbe_pkg::OP_LINE_RX:
            begin
                if (rx_head_inc != rx_tail_reg)
                    rx_wr = 1'b1;
                else
                    drop = 1'b1;
            end
            urbe_pkg::OP_TX_EMPTY:
            begin
                if (irq_reg)
                begin
                    if (tx_head_reg != tx_tail_reg)
                        tx_rd = 1'b1;
                    else
                        irq_next = 1'b0;
                end
            end
            urbe_pkg::OP_HOST_RD:
            begin
                rx_rd = (rx_head_reg != rx_tail_reg);
            end
            urbe_pkg::OP_HOST_WR:
            begin
                // no interrupt pending: hand the byte straight to the line
                if (!(idle_reg && irq_reg))
                begin
                    direct   = 1'b1;
                    irq_next = 1'b1;
                end
                else if (tx_head_inc != tx_tail_reg)
                    tx_wr = 1'b1;
                else
                    drop = 1'b1;
            end
            default:
            begin
                drop = 1'b0;
            end
        endcase
    end

    // Beat capture (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_op;
            data_reg <= in_data;
            idle_reg <= in_idle;
        end
    end

    // Queue memories: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.exec && rx_wr)
            rx_mem[rx_head_reg] <= data_reg;
        if (cmd.exec && rx_rd)
            rx_rd_reg <= rx_mem[rx_tail_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && tx_wr)
            tx_mem[tx_head_reg] <= data_reg;
        if (cmd.exec && tx_rd)
            tx_rd_reg <= tx_mem[tx_tail_reg];
    end

    // Pointers, interrupt enable and step flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            irq_reg     <= 1'b1;
            rvalid_reg  <= 1'b0;
            svalid_reg  <= 1'b0;
            direct_reg  <= 1'b0;
            drop_reg    <= 1'b0;
        end
        else if (cmd.exec)
        begin
            if (rx_wr)
                rx_head_reg <= rx_head_inc;
            if (rx_rd)
                rx_tail_reg <= rx_tail_inc;
            if (tx_wr)
                tx_head_reg <= tx_head_inc;
            if (tx_rd)
                tx_tail_reg <= tx_tail_inc;
            irq_reg    <= irq_next;
            rvalid_reg <= rx_rd;
            svalid_reg <= tx_rd | direct;
            direct_reg <= direct;
            drop_reg   <= drop;
        end
    end

    // Result fields
    assign rbyte = rvalid_reg ? rx_rd_reg : '0;
    assign sbyte = !svalid_reg ? '0 : (direct_reg ? data_reg : tx_rd_reg);

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_data_reg <= {(urbe_pkg::OUT_TDATA_W - urbe_pkg::OUT_USED_W)'(0),
                             drop_reg, irq_reg, svalid_reg, sbyte, rvalid_reg, rbyte};
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_data      = out_data_reg;
    assign sts.out_stall = out_valid_reg && !out_ready;

endmodule

// File: hdl/uart_ring_buffer_engine.sv
`timescale 1ns / 1ps
// UART ring-buffer engine: receive and transmit byte queues between line and host.
// An accepted input beat goes through the execute step, then the load step, which raises m_tvalid.
// One item at a time (accept, queue update with memory access, result load); no new beat is taken before the load.
// Result stalls hold the sequencer in its load step; s_tready stays low while an item is busy.
// Reset: asynchronous, active low; pointers cleared, transmit-empty interrupt enabled.
// Depends on urbe_pkg, urbe_ctrl and urbe_datapath.

module uart_ring_buffer_engine
#(
    parameter int RX_DEPTH = urbe_pkg::RX_DEPTH_DEF,
    parameter int TX_DEPTH = urbe_pkg::TX_DEPTH_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [7:0] data, [8] line_idle, [15:9] zero
    input  logic [urbe_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [1:0] op
    input  logic [urbe_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] read_byte, [8] read_valid, [16:9] send_byte, [17] send_valid,
    // [18] tx_irq_on, [19] dropped, [23:20] zero
    output logic [urbe_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    urbe_pkg::cmd_t cmd;
    urbe_pkg::sts_t sts;

    urbe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    urbe_datapath
    #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_op     (s_tuser),
        .in_data   (s_tdata[urbe_pkg::BYTE_W-1:0]),
        .in_idle   (s_tdata[urbe_pkg::IN_IDLE_BIT]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // One item in flight: an accepted beat closes the input for the next cycle
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous item still executing");

    // A step never both returns a host byte and sends one
    a_rd_send_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[urbe_pkg::OUT_RVALID_BIT] && m_tdata[urbe_pkg::OUT_SVALID_BIT]))
        else $error("read and send reported in one result");

    // Sending a byte always leaves the transmit interrupt enabled
    a_send_irq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[urbe_pkg::OUT_SVALID_BIT] |-> m_tdata[urbe_pkg::OUT_IRQ_BIT])
        else $error("byte sent with transmit interrupt disabled");

    // A dropped byte never goes to the line
    a_drop_nosend: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[urbe_pkg::OUT_DROP_BIT] |-> !m_tdata[urbe_pkg::OUT_SVALID_BIT])
        else $error("byte both dropped and sent");

endmodule

// File: tb/sv/uart_ring_buffer_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for uart_ring_buffer_engine: a directed table, then shaped random traffic.
// Every result beat is checked against a cycle-free mirror of both byte queues.
// Depends on urbe_pkg and the uart_ring_buffer_engine RTL.

module uart_ring_buffer_engine_tb;

    localparam int NUM_RANDOM   = 2000;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 200;

    // Result beat, same bit order as m_tdata[19:0]
    typedef struct packed {
        logic       drop;
        logic       irq_en;
        logic       tx_ok;
        logic [7:0] tx_byte;
        logic       rd_ok;
        logic [7:0] rd_byte;
    } ring_res_t;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       idle;
        bit         typed;
        ring_res_t  res;
    } dir_row_t;

    typedef enum int
    {
        MODE_MIX,
        MODE_RX_FILL,
        MODE_RX_DRAIN,
        MODE_TX_FILL,
        MODE_TX_DRAIN
    } traffic_mode_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [urbe_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [urbe_pkg::OP_W-1:0]        s_tuser;
    logic                             m_tvalid;
    logic                             m_tready;
    logic [urbe_pkg::OUT_TDATA_W-1:0] m_tdata;

    // Mirror of the queues and interrupt enable
    logic [7:0] rx_mem [urbe_pkg::RX_DEPTH_DEF];
    logic [7:0] tx_mem [urbe_pkg::TX_DEPTH_DEF];
    int         rx_wr = 0;
    int         rx_rd = 0;
    int         tx_wr = 0;
    int         tx_rd = 0;
    logic       irq_en_m = 1'b1;

    ring_res_t  pending_res_q[$];
    int         n_accepted = 0;
    int         n_mismatch = 0;
    int         cycle_count = 0;
    bit         hold_done = 1'b0;

    uart_ring_buffer_engine u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run-time guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Both sides run without idles in this window
    function automatic bit in_quiet_stretch();
        return (n_accepted >= 1200) && (n_accepted < 1500);
    endfunction

    // Apply one item to the queue mirror and return the result it causes
    function automatic ring_res_t predict_ring_step(input logic [1:0] op, input logic [7:0] data,
                                                    input logic idle);
        ring_res_t r;
        int        nxt;
        r = '0;
        case (op)
            urbe_pkg::OP_LINE_RX:
            begin
                nxt = (rx_wr + 1) % urbe_pkg::RX_DEPTH_DEF;
                if (nxt != rx_rd)
                begin
                    rx_mem[rx_wr] = data;
                    rx_wr = nxt;
                end
                else
                    r.drop = 1'b1;
            end
            urbe_pkg::OP_TX_EMPTY:
            begin
                // no interrupt while disabled, so nothing happens
                if (irq_en_m)
                begin
                    if (tx_wr != tx_rd)
                    begin
                        r.tx_byte = tx_mem[tx_rd];
                        r.tx_ok   = 1'b1;
                        tx_rd     = (tx_rd + 1) % urbe_pkg::TX_DEPTH_DEF;
                    end
                    else
                        irq_en_m = 1'b0;
                end
            end
            urbe_pkg::OP_HOST_RD:
            begin
                if (rx_wr != rx_rd)
                begin
                    r.rd_byte = rx_mem[rx_rd];
                    r.rd_ok   = 1'b1;
                    rx_rd     = (rx_rd + 1) % urbe_pkg::RX_DEPTH_DEF;
                end
            end
            default:
            begin
                // interrupt pending only when line idle and enable set
                if (!(idle && irq_en_m))
                begin
                    r.tx_byte = data;
                    r.tx_ok   = 1'b1;
                    irq_en_m  = 1'b1;
                end
                else
                begin
                    nxt = (tx_wr + 1) % urbe_pkg::TX_DEPTH_DEF;
                    if (nxt != tx_rd)
                    begin
                        tx_mem[tx_wr] = data;
                        tx_wr = nxt;
                    end
                    else
                        r.drop = 1'b1;
                end
            end
        endcase
        r.irq_en = irq_en_m;
        return r;
    endfunction

    function automatic dir_row_t mk_row(input logic [1:0] op, input logic [7:0] data,
                                        input logic idle, input int typed,
                                        input logic [7:0] rd_byte, input int rd_ok,
                                        input logic [7:0] tx_byte, input int tx_ok,
                                        input int irq_en, input int drop);
        dir_row_t row;
        row.op          = op;
        row.data        = data;
        row.idle        = idle;
        row.typed       = (typed != 0);
        row.res.rd_byte = rd_byte;
        row.res.rd_ok   = (rd_ok != 0);
        row.res.tx_byte = tx_byte;
        row.res.tx_ok   = (tx_ok != 0);
        row.res.irq_en  = (irq_en != 0);
        row.res.drop    = (drop != 0);
        return row;
    endfunction

    // Offer one beat, sometimes after a random idle gap; log the expected result on acceptance
    task automatic offer_beat(input logic [1:0] op, input logic [7:0] data, input logic idle,
                              input bit typed, input ring_res_t typed_res);
        ring_res_t pred;
        if (!in_quiet_stretch() && ($urandom_range(0, 99) < 14))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, idle, data};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_ring_step(op, data, idle);
        pending_res_q.push_back(typed ? typed_res : pred);
        n_accepted++;
    endtask

    // Result side: random stalls plus one long hold-off while the input keeps offering
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && (n_accepted >= 300))
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= in_quiet_stretch() || ($urandom_range(0, 99) >= 14);
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : check_beat
        ring_res_t got;
        ring_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[urbe_pkg::OUT_USED_W-1:0];
            if (pending_res_q.size() == 0)
            begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: result beat with nothing expected: %p", $realtime, got);
            end
            else
            begin
                want = pending_res_q.pop_front();
                if ((got.rd_byte !== want.rd_byte) || (got.rd_ok !== want.rd_ok) ||
                    (got.tx_byte !== want.tx_byte) || (got.tx_ok !== want.tx_ok) ||
                    (got.irq_en !== want.irq_en) || (got.drop !== want.drop))
                begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: expected %p, got %p", $realtime, want, got);
                end
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t      rows[$];
        traffic_mode_t mode;
        int            seg_left;
        int            seg_idx;
        int            pick;
        logic [1:0]    op;
        logic [7:0]    data;
        logic          idle;

        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= urbe_pkg::OP_LINE_RX;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // op, data, idle, typed | rd_byte, rd_ok, tx_byte, tx_ok, irq_en, drop
        // empty read
        rows.push_back(mk_row(urbe_pkg::OP_HOST_RD, 8'h00, 1'b0, 1, 8'h00, 0, 8'h00, 0, 1, 0));
        // irq off
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 1, 8'h00, 0, 8'h00, 0, 0, 0));
        // disabled
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'hFF, 1'b1, 1, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'hFF, 1'b1, 1, 8'h00, 0, 8'hFF, 1, 1, 0));
        // busy line
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'h00, 1'b0, 1, 8'h00, 0, 8'h00, 1, 1, 0));
        // pending
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'hA5, 1'b1, 1, 8'h00, 0, 8'h00, 0, 1, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'h5A, 1'b1, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 1, 8'h00, 0, 8'hA5, 1, 1, 0));
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 1, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_LINE_RX, 8'h00, 1'b1, 1, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_LINE_RX, 8'hFF, 1'b0, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_LINE_RX, 8'h3C, 1'b1, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_RD, 8'h00, 1'b0, 1, 8'h00, 1, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_RD, 8'h00, 1'b0, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_RD, 8'hFF, 1'b1, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        // empty
        rows.push_back(mk_row(urbe_pkg::OP_HOST_RD, 8'h00, 1'b0, 1, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'h81, 1'b1, 1, 8'h00, 0, 8'h81, 1, 1, 0));
        rows.push_back(mk_row(urbe_pkg::OP_HOST_WR, 8'h7E, 1'b1, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'hFF, 1'b1, 0, 8'h00, 0, 8'h00, 0, 0, 0));
        rows.push_back(mk_row(urbe_pkg::OP_TX_EMPTY, 8'h00, 1'b0, 0, 8'h00, 0, 8'h00, 0, 0, 0));

        foreach (rows[i])
            offer_beat(rows[i].op, rows[i].data, rows[i].idle, rows[i].typed, rows[i].res);

        // Random traffic in segments; the first two fill each queue past full
        seg_left = 0;
        seg_idx  = 0;
        mode     = MODE_MIX;
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            if (seg_left == 0)
            begin
                if (seg_idx == 0)
                    mode = MODE_RX_FILL;
                else if (seg_idx == 1)
                    mode = MODE_TX_FILL;
                else
                    mode = traffic_mode_t'($urandom_range(0, 4));
                seg_left = (seg_idx < 2) ? 320 : $urandom_range(40, 320);
                seg_idx++;
            end
            seg_left--;

            // sender pause until every result is back
            if (n == 1000)
            begin
                s_tvalid <= 1'b0;
                while (pending_res_q.size() != 0)
                    @(posedge clk);
            end

            pick = $urandom_range(0, 99);
            data = 8'($urandom_range(0, 255));
            idle = 1'($urandom_range(0, 1));
            case (mode)
                MODE_RX_FILL:  op = (pick < 80) ? urbe_pkg::OP_LINE_RX : urbe_pkg::OP_HOST_RD;
                MODE_RX_DRAIN: op = (pick < 80) ? urbe_pkg::OP_HOST_RD : urbe_pkg::OP_LINE_RX;
                MODE_TX_FILL:
                begin
                    op   = (pick < 85) ? urbe_pkg::OP_HOST_WR : urbe_pkg::OP_TX_EMPTY;
                    idle = ($urandom_range(0, 99) < 92);
                end
                MODE_TX_DRAIN: op = (pick < 80) ? urbe_pkg::OP_TX_EMPTY : urbe_pkg::OP_HOST_WR;
                default:       op = 2'($urandom_range(0, 3));
            endcase
            offer_beat(op, data, idle, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        // Drain remaining results, then a few spare cycles for stray beats
        while (pending_res_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_mismatch == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
